// File: src/grs_pkg.sv
// ============================================================================
// GOOSE retransmit scheduler package
// Shared codes, widths and the result record of the retransmit scheduler.
// ============================================================================
`default_nettype none

package grs_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_TTL  = 2'd0;
    localparam logic [1:0] REG_FAST_TTL = 2'd1;
    localparam logic [1:0] REG_MAX_LAG  = 2'd2;

    // Input beat kinds
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Result kinds
    localparam logic [1:0] RK_FETCH      = 2'd0;
    localparam logic [1:0] RK_CHANGE     = 2'd1;
    localparam logic [1:0] RK_RETRANSMIT = 2'd2;

    // Reset values
    localparam logic [15:0] MAX_TTL_RST  = 16'd2000;
    localparam logic [15:0] FAST_TTL_RST = 16'd20;
    localparam logic [15:0] MAX_LAG_RST  = 16'd5;
    localparam logic [15:0] TTL_RST      = 16'd2000;
    localparam logic [15:0] COUNTDOWN_RST = 16'd1000;

    // Packed widths of the stream payloads
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;

    // One result beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  channel;
        logic [15:0] index;
        logic [15:0] ttl;
        logic [31:0] sn;
        logic        last;
    } grs_result_t;

endpackage

`default_nettype wire

// File: src/goose_retransmit_scheduler.sv
// ============================================================================
// GOOSE retransmit scheduler
// Tracks per-channel ring indexes, issues sample fetches, publishes state
// changes and schedules retransmissions on millisecond ticks.
// ============================================================================
//
//  Channel   Direction  Handshake             Payload
//  s_*       in         s_tvalid / s_tready   tuser kind, tlast end_of_scan,
//                                             tdata channel, write_index,
//                                             ring_items
//  m_*       out        m_tvalid / m_tready   tuser result_kind, tlast last,
//                                             tdata fetch_channel, fetch_index,
//                                             ttl_ms, state_number
//  cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// An accepted beat is registered in the input register and is then resolved
// combinationally into the output register. A beat gives at most two
// results; the second waits in a hold register, which stalls the input
// register until that result moves on. One beat per cycle is sustained
// while each beat gives at most one result and the output is not stalled.
// Reset is synchronous and active low; cfg_ready is always high.
`default_nettype none

module goose_retransmit_scheduler #(
    parameter int CHANNELS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [3:0] channel, [19:4] write_index, [36:20] ring_items, zero fill
    input  wire logic [grs_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] kind
    input  wire logic                             s_tuser,
    input  wire logic                             s_tlast,
    // Result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [3:0] fetch_channel, [19:4] fetch_index, [35:20] ttl_ms,
    // [67:36] state_number, zero fill
    output logic [grs_pkg::M_TDATA_W-1:0]         m_tdata,
    // [1:0] result_kind
    output logic [1:0]                            m_tuser,
    output logic                                  m_tlast,
    // Configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [1:0]                       cfg_index,
    input  wire logic [15:0]                      cfg_data
);

    import grs_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [8:0] CHAN_LIM = 9'(CHANNELS);

    // Configuration registers
    logic [15:0] max_ttl_reg;
    logic [15:0] fast_ttl_reg;
    logic [15:0] max_lag_reg;

    // Scheduler state
    logic [15:0] next_index_reg [CHANNELS];
    logic        change_seen_reg;
    logic [15:0] ttl_reg;
    logic [15:0] countdown_reg;
    logic [31:0] sn_reg;

    // Input register
    logic        in_valid_reg;
    logic        in_kind_reg;
    logic [3:0]  in_ch_reg;
    logic [15:0] in_widx_reg;
    logic [16:0] in_items_reg;
    logic        in_eos_reg;

    // Output and hold registers
    logic        out_valid_reg;
    grs_result_t out_reg;
    logic        hold_valid_reg;
    grs_result_t hold_reg;

    // Resolve logic
    logic        out_free;
    logic        fire;
    logic [8:0]  ch_ext;
    logic [CH_W-1:0] ch_idx;
    logic        ch_ok;
    logic [16:0] items_eff;
    logic [15:0] old_idx;
    logic signed [17:0] diff;
    logic signed [17:0] ring_dist;
    logic        jump;
    logic [16:0] adv;
    logic [15:0] nx;
    logic        do_fetch;
    logic        change_next;
    logic        do_publish;
    logic [31:0] sn_inc;
    logic        due;
    logic [16:0] ttl_dbl;
    logic [15:0] ttl_cap;
    logic [1:0]  n_res;
    grs_result_t r_fetch;
    grs_result_t r_pub;
    grs_result_t r_tick;
    grs_result_t res0;
    grs_result_t res1;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_free && !hold_valid_reg;
    assign s_tready  = !in_valid_reg || fire;

    // Channel report: ring distance, jump or advance
    always_comb begin
        ch_ext    = {5'b0, in_ch_reg};
        ch_idx    = ch_ext[CH_W-1:0];
        ch_ok     = ch_ext < CHAN_LIM;
        items_eff = in_items_reg;
        if (in_items_reg == 17'd0 || (in_items_reg[16] && in_items_reg[15:0] != 16'd0)) begin
            items_eff = 17'h10000;
        end
        old_idx   = ch_ok ? next_index_reg[ch_idx] : 16'd0;
        diff      = $signed({2'b00, in_widx_reg}) - $signed({2'b00, old_idx});
        ring_dist = diff[17] ? diff + $signed({1'b0, items_eff}) : diff;
        jump      = ring_dist > $signed({2'b00, max_lag_reg});
        adv       = {1'b0, old_idx} + 17'd1;
        if (jump) begin
            nx = in_widx_reg;
        end else if (adv >= items_eff) begin
            nx = 16'd0;
        end else begin
            nx = adv[15:0];
        end
        do_fetch    = ch_ok && (old_idx != in_widx_reg);
        change_next = change_seen_reg || do_fetch;
        do_publish  = in_eos_reg && change_next;
        sn_inc      = sn_reg + 32'd1;
    end

    // Millisecond tick: deadline and TTL doubling
    always_comb begin
        due     = countdown_reg <= 16'd1;
        ttl_dbl = {ttl_reg, 1'b0};
        ttl_cap = (ttl_dbl > {1'b0, max_ttl_reg}) ? max_ttl_reg : ttl_dbl[15:0];
    end

    // Result records and their order
    always_comb begin
        r_fetch = '{kind: RK_FETCH, channel: in_ch_reg, index: nx,
                    ttl: 16'd0, sn: 32'd0, last: !do_publish};
        r_pub   = '{kind: RK_CHANGE, channel: 4'd0, index: 16'd0,
                    ttl: fast_ttl_reg, sn: sn_inc, last: 1'b1};
        r_tick  = '{kind: RK_RETRANSMIT, channel: 4'd0, index: 16'd0,
                    ttl: ttl_cap, sn: sn_reg, last: 1'b1};
        res1 = r_pub;
        if (in_kind_reg == KIND_TICK) begin
            res0  = r_tick;
            n_res = due ? 2'd1 : 2'd0;
        end else if (do_fetch) begin
            res0  = r_fetch;
            n_res = do_publish ? 2'd2 : 2'd1;
        end else begin
            res0  = r_pub;
            n_res = do_publish ? 2'd1 : 2'd0;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_ttl_reg  <= MAX_TTL_RST;
            fast_ttl_reg <= FAST_TTL_RST;
            max_lag_reg  <= MAX_LAG_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAX_TTL:  max_ttl_reg  <= cfg_data;
                REG_FAST_TTL: fast_ttl_reg <= cfg_data;
                REG_MAX_LAG:  max_lag_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg  <= s_tuser;
            in_ch_reg    <= s_tdata[3:0];
            in_widx_reg  <= s_tdata[19:4];
            in_items_reg <= s_tdata[36:20];
            in_eos_reg   <= s_tlast;
        end
    end

    // Scheduler state update, once per resolved beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                next_index_reg[i] <= 16'd0;
            end
            change_seen_reg <= 1'b0;
            ttl_reg         <= TTL_RST;
            countdown_reg   <= COUNTDOWN_RST;
            sn_reg          <= 32'd0;
        end else if (fire) begin
            if (in_kind_reg == KIND_TICK) begin
                if (due) begin
                    ttl_reg       <= ttl_cap;
                    countdown_reg <= {1'b0, ttl_cap[15:1]};
                end else begin
                    countdown_reg <= countdown_reg - 16'd1;
                end
            end else begin
                if (do_fetch) begin
                    next_index_reg[ch_idx] <= nx;
                end
                if (do_publish) begin
                    change_seen_reg <= 1'b0;
                    sn_reg          <= sn_inc;
                    ttl_reg         <= fast_ttl_reg;
                    countdown_reg   <= {1'b0, fast_ttl_reg[15:1]};
                end else begin
                    change_seen_reg <= change_next;
                end
            end
        end
    end

    // Output register with a hold stage for the second result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg  <= n_res != 2'd0;
            hold_valid_reg <= n_res == 2'd2;
        end else if (out_free && hold_valid_reg) begin
            out_valid_reg  <= 1'b1;
            hold_valid_reg <= 1'b0;
        end else if (m_tready) begin
            out_valid_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg  <= res0;
            hold_reg <= res1;
        end else if (out_free && hold_valid_reg) begin
            out_reg  <= hold_reg;
        end
    end

    // Result beat packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {4'd0, out_reg.sn, out_reg.ttl, out_reg.index, out_reg.channel};

endmodule

`default_nettype wire
